### hw/rtl/pwmbd_pkg.sv
// pwmbd_pkg: types and constants for the pulse width bit decoder.
// No dependencies; used by pwm_pulse_width_bit_decoder.
`default_nettype none

package pwmbd_pkg;

    localparam int DUR_W   = 15;
    localparam int CNT_W   = 7;
    localparam int CFG_IDX_W = 3;

    localparam logic [CNT_W-1:0] HARD_BIT_CAP = 7'd66;

    localparam logic [DUR_W-1:0] HEADER_MIN_RST = 15'd3500;
    localparam logic [DUR_W-1:0] HIGH_MIN_RST   = 15'd200;
    localparam logic [DUR_W-1:0] HIGH_MAX_RST   = 15'd1300;
    localparam logic [DUR_W-1:0] SHORT_HIGH_RST = 15'd680;
    localparam logic [DUR_W-1:0] GAP_RST        = 15'd2000;
    localparam logic [CNT_W-1:0] BIT_LIMIT_RST  = 7'd66;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER_MIN = 3'd0,
        CFG_HIGH_MIN   = 3'd1,
        CFG_HIGH_MAX   = 3'd2,
        CFG_SHORT_HIGH = 3'd3,
        CFG_GAP        = 3'd4,
        CFG_BIT_LIMIT  = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_SEARCH = 3'b001,
        PH_DECODE = 3'b010,
        PH_STOP   = 3'b100
    } phase_t;

endpackage

`default_nettype wire

### hw/rtl/pwm_pulse_width_bit_decoder.sv
// pwm_pulse_width_bit_decoder: header search and high-duration bit decode.
// Depends on pwmbd_pkg.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+---------------------------------------------
//  symbol   | in        | in_valid / in_stall | level_first dur_first level_second dur_second
//           |           |                     | last_symbol
//  result   | out       | out_valid/out_stall | bit_valid bit_value bit_index done_res
//           |           |                     | bit_count status
//  config   | in        | cfg_we              | cfg_index cfg_data
//
// A symbol is decoded in the cycle it is accepted; its registered results show in the
// cycle after. One symbol per cycle while out_stall is low and each symbol yields at most
// one result; a last symbol with a bit sends a bit beat then a done beat through one port.
// in_stall rises while out_stall blocks held results, or while both beats are held.
// Reset puts decoding in header search with zero bits and loads default limits.
`default_nettype none

module pwm_pulse_width_bit_decoder (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              cfg_we,
    input  wire logic [pwmbd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pwmbd_pkg::DUR_W-1:0]       cfg_data,

    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              level_first,
    input  wire logic [pwmbd_pkg::DUR_W-1:0]       dur_first,
    input  wire logic                              level_second,
    input  wire logic [pwmbd_pkg::DUR_W-1:0]       dur_second,
    input  wire logic                              last_symbol,

    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   bit_valid,
    output logic                                   bit_value,
    output logic [pwmbd_pkg::CNT_W-1:0]            bit_index,
    output logic                                   done_res,
    output logic [pwmbd_pkg::CNT_W-1:0]            bit_count,
    output logic                                   status
);

    logic [pwmbd_pkg::DUR_W-1:0] header_min_reg;
    logic [pwmbd_pkg::DUR_W-1:0] high_min_reg;
    logic [pwmbd_pkg::DUR_W-1:0] high_max_reg;
    logic [pwmbd_pkg::DUR_W-1:0] short_high_reg;
    logic [pwmbd_pkg::DUR_W-1:0] gap_reg;
    logic [pwmbd_pkg::CNT_W-1:0] bit_limit_reg;

    pwmbd_pkg::phase_t           phase_reg, phase_next, phase_mid;
    logic [pwmbd_pkg::CNT_W-1:0] bits_reg, bits_next, bits_mid, bits_inc;

    logic                        bit_pend_reg, done_pend_reg;
    logic                        bit_value_reg;
    logic [pwmbd_pkg::CNT_W-1:0] bit_index_reg;
    logic [pwmbd_pkg::CNT_W-1:0] done_count_reg;
    logic                        done_status_reg;

    logic                        in_take, out_take;
    logic [pwmbd_pkg::CNT_W-1:0] limit;
    logic [pwmbd_pkg::DUR_W-1:0] hi_dur, lo_dur;
    logic                        is_header;
    logic                        emit_bit;
    logic                        emit_value;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_min_reg <= pwmbd_pkg::HEADER_MIN_RST;
            high_min_reg   <= pwmbd_pkg::HIGH_MIN_RST;
            high_max_reg   <= pwmbd_pkg::HIGH_MAX_RST;
            short_high_reg <= pwmbd_pkg::SHORT_HIGH_RST;
            gap_reg        <= pwmbd_pkg::GAP_RST;
            bit_limit_reg  <= pwmbd_pkg::BIT_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pwmbd_pkg::CFG_HEADER_MIN: header_min_reg <= cfg_data;
                pwmbd_pkg::CFG_HIGH_MIN:   high_min_reg   <= cfg_data;
                pwmbd_pkg::CFG_HIGH_MAX:   high_max_reg   <= cfg_data;
                pwmbd_pkg::CFG_SHORT_HIGH: short_high_reg <= cfg_data;
                pwmbd_pkg::CFG_GAP:        gap_reg        <= cfg_data;
                pwmbd_pkg::CFG_BIT_LIMIT:  bit_limit_reg  <= cfg_data[pwmbd_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake
    assign out_valid = bit_pend_reg | done_pend_reg;
    assign out_take  = out_valid & ~out_stall;
    assign in_stall  = (bit_pend_reg & done_pend_reg) | (out_valid & out_stall);
    assign in_take   = in_valid & ~in_stall;

    // decode
    assign limit     = (bit_limit_reg < pwmbd_pkg::HARD_BIT_CAP) ? bit_limit_reg
                                                                 : pwmbd_pkg::HARD_BIT_CAP;
    assign hi_dur    = level_first ? dur_first : dur_second;
    assign lo_dur    = level_first ? dur_second : dur_first;
    assign is_header = (~level_first & (dur_first > header_min_reg)) |
                       (~level_second & (dur_second > header_min_reg));
    assign bits_inc  = bits_reg + 7'd1;

    always_comb
    begin
        phase_mid  = phase_reg;
        bits_mid   = bits_reg;
        emit_bit   = 1'b0;
        emit_value = 1'b0;
        case (phase_reg)
            pwmbd_pkg::PH_SEARCH:
            begin
                if (is_header)
                    phase_mid = pwmbd_pkg::PH_DECODE;
            end
            pwmbd_pkg::PH_DECODE:
            begin
                if (bits_reg >= limit)
                    phase_mid = pwmbd_pkg::PH_STOP;
                else if ((hi_dur < high_min_reg) || (hi_dur > high_max_reg))
                    phase_mid = pwmbd_pkg::PH_STOP;
                else
                begin
                    emit_bit   = 1'b1;
                    emit_value = hi_dur < short_high_reg;
                    bits_mid   = bits_inc;
                    if ((lo_dur > gap_reg) || (bits_inc >= limit))
                        phase_mid = pwmbd_pkg::PH_STOP;
                end
            end
            default: ;
        endcase

        if (last_symbol)
        begin
            phase_next = pwmbd_pkg::PH_SEARCH;
            bits_next  = '0;
        end
        else
        begin
            phase_next = phase_mid;
            bits_next  = bits_mid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= pwmbd_pkg::PH_SEARCH;
            bits_reg      <= '0;
            bit_pend_reg  <= 1'b0;
            done_pend_reg <= 1'b0;
        end
        else if (in_take)
        begin
            phase_reg     <= phase_next;
            bits_reg      <= bits_next;
            bit_pend_reg  <= emit_bit;
            done_pend_reg <= last_symbol;
        end
        else if (out_take)
        begin
            if (bit_pend_reg)
                bit_pend_reg <= 1'b0;
            else
                done_pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            bit_value_reg   <= emit_value;
            bit_index_reg   <= bits_reg;
            done_count_reg  <= bits_mid;
            done_status_reg <= (phase_mid == pwmbd_pkg::PH_SEARCH);
        end
    end

    // bit beat goes first, done beat after
    assign bit_valid = bit_pend_reg;
    assign bit_value = bit_pend_reg & bit_value_reg;
    assign bit_index = bit_pend_reg ? bit_index_reg : '0;
    assign done_res  = ~bit_pend_reg & done_pend_reg;
    assign bit_count = done_res ? done_count_reg : '0;
    assign status    = done_res & done_status_reg;

`ifndef SYNTHESIS
    a_bits_cap: assert property (@(posedge clk) disable iff (!rst_n)
        bits_reg <= pwmbd_pkg::HARD_BIT_CAP)
        else $error("bit counter past hard cap");

    a_search_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == pwmbd_pkg::PH_SEARCH) |-> (bits_reg == '0))
        else $error("bits counted while searching for header");

    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (bit_pend_reg && done_pend_reg) |-> in_stall)
        else $error("symbol taken with two results held");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && bit_pend_reg && done_pend_reg) |=> (done_res && out_valid))
        else $error("done beat lost after bit beat");

    a_pend_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(bit_pend_reg) && $stable(done_pend_reg))
        else $error("held results changed under stall");
`endif

endmodule

`default_nettype wire
